// ===== rtl/core/apq_pkg.sv =====
package apq_pkg;

   localparam int IdW   = 16;
   localparam int PrioW = 8;
   localparam int OccW  = 5;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_RETRIEVE = 2'd1,
      REQ_FINISH   = 2'd2,
      REQ_NOP      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FINISHED = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IdW-1:0]   item_id;
      logic [PrioW-1:0] item_priority;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IdW-1:0]   out_id;
      logic [OccW-1:0]  occupancy;
   } rsp_word_type;

   // one slot of the sorted chain
   typedef struct packed {
      logic             valid;
      logic [IdW-1:0]   id;
      logic [PrioW-1:0] prio;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic             insert;
      logic             pop;
      logic [IdW-1:0]   id;
      logic [PrioW-1:0] prio;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/apq_cell.sv =====
module apq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  apq_pkg::cell_ctrl_type ctrl,
   input  apq_pkg::entry_type     left_entry,
   input  logic                   left_greater,
   input  apq_pkg::entry_type     right_entry,
   output apq_pkg::entry_type     entry,
   output logic                   greater
);

   apq_pkg::entry_type entry_ff;
   apq_pkg::entry_type entry_in;
   apq_pkg::entry_type new_entry;
   apq_pkg::entry_type aged_entry;

   assign greater = entry_ff.valid && (entry_ff.prio > ctrl.prio);
   assign entry   = entry_ff;

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.id    = ctrl.id;
      new_entry.prio  = ctrl.prio;

      // pop shifts toward the head; the shifted entry ages, floor of 1
      aged_entry = right_entry;
      if (right_entry.prio > apq_pkg::PrioW'(1)) begin
         aged_entry.prio = right_entry.prio - apq_pkg::PrioW'(1);
      end

      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = aged_entry;
      end else if (ctrl.insert && (greater || !entry_ff.valid)) begin
         if (left_greater) begin
            entry_in = left_entry;          // make room: shift toward tail
         end else if (greater || left_entry.valid) begin
            entry_in = new_entry;           // insertion point
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id   <= entry_in.id;
      entry_ff.prio <= entry_in.prio;
   end

endmodule

// ===== rtl/core/aging_priority_queue_top.sv =====
// Channel | Dir | Handshake            | Word
// req     | in  | req_valid/req_ready  | req_data : apq_pkg::req_word_type
// rsp     | out | rsp_valid/rsp_ready  | rsp_data : apq_pkg::rsp_word_type
//
// One word in, one word out. A request is executed in the cycle it is taken;
// its response sits in the output register from the next cycle on.
// One request per cycle while the response side keeps up; the response
// register is the only stall point (req_ready = output register free or
// being drained). Reset empties the queue and clears the done flag.
module aging_priority_queue_top #(
   parameter int DEPTH    = 16,
   parameter int MAX_PRIO = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  apq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output apq_pkg::rsp_word_type rsp_data
);

   localparam int CntW = $clog2(DEPTH + 1);

   // queue bookkeeping
   logic [CntW-1:0]       count_ff;
   logic [CntW-1:0]       count_in;
   logic                  finished_ff;
   logic                  finished_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   apq_pkg::rsp_word_type rsp_data_ff;
   apq_pkg::rsp_word_type rsp_data_in;

   logic                  req_fire;
   logic                  is_full;
   logic                  is_empty;
   logic [apq_pkg::PrioW-1:0] prio_clamped;
   logic [CntW+apq_pkg::OccW-1:0] occ_wide;

   apq_pkg::cell_ctrl_type ctrl;

   // cell chain: index 0 is the head
   apq_pkg::entry_type cell_entry [DEPTH];
   logic               cell_greater [DEPTH];
   logic [DEPTH-1:0]   valid_vec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_full  = (count_ff == CntW'(DEPTH));
   assign is_empty = (count_ff == '0);

   // saturate incoming priority into 1..MAX_PRIO
   always_comb begin
      if (req_data.item_priority == '0) begin
         prio_clamped = apq_pkg::PrioW'(1);
      end else if (32'(req_data.item_priority) > 32'(MAX_PRIO)) begin
         prio_clamped = apq_pkg::PrioW'(MAX_PRIO);
      end else begin
         prio_clamped = req_data.item_priority;
      end
   end

   always_comb begin
      ctrl.insert = req_fire && (req_data.req_type == apq_pkg::REQ_INSERT) && !is_full;
      ctrl.pop    = req_fire && (req_data.req_type == apq_pkg::REQ_RETRIEVE) && !is_empty;
      ctrl.id     = req_data.item_id;
      ctrl.prio   = prio_clamped;
   end

   // the chain: each cell sees its neighbors and the broadcast request
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         apq_pkg::entry_type left_e;
         apq_pkg::entry_type right_e;
         logic               left_g;

         if (gi == 0) begin : g_head
            // head: an always-present, never-greater left side
            assign left_e = '{valid: 1'b1, id: '0, prio: '0};
            assign left_g = 1'b0;
         end else begin : g_body
            assign left_e = cell_entry[gi-1];
            assign left_g = cell_greater[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign right_e = '0;            // vacated slot reads empty
         end else begin : g_inner
            assign right_e = cell_entry[gi+1];
         end

         apq_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .left_entry   (left_e),
            .left_greater (left_g),
            .right_entry  (right_e),
            .entry        (cell_entry[gi]),
            .greater      (cell_greater[gi])
         );

         assign valid_vec[gi] = cell_entry[gi].valid;
      end
   endgenerate

   // next count, flag and response word
   always_comb begin
      count_in     = count_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in.status = apq_pkg::ST_OK;
      rsp_data_in.out_id = '0;

      case (req_data.req_type)
         apq_pkg::REQ_INSERT: begin
            if (is_full) begin
               rsp_data_in.status = apq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CntW'(1);
            end
         end
         apq_pkg::REQ_RETRIEVE: begin
            if (is_empty) begin
               rsp_data_in.status = finished_ff ? apq_pkg::ST_FINISHED : apq_pkg::ST_EMPTY;
            end else begin
               rsp_data_in.out_id = cell_entry[0].id;
               count_in = count_ff - CntW'(1);
            end
         end
         apq_pkg::REQ_FINISH: begin
            finished_in = 1'b1;
         end
         default: begin
         end
      endcase

      // occupancy is reported modulo 2^OccW
      occ_wide = (CntW + apq_pkg::OccW)'(count_in);
      rsp_data_in.occupancy = occ_wide[apq_pkg::OccW-1:0];

      if (!req_fire) begin
         count_in    = count_ff;
         finished_in = finished_ff;
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   // count tracks the number of occupied cells
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CntW'($countones(valid_vec)))
      else $error("entry count disagrees with occupied cells");

   // the tail cell is occupied exactly when the queue is full
   a_full_tail: assert property (@(posedge clock) disable iff (reset)
      is_full == valid_vec[DEPTH-1])
      else $error("tail cell occupancy disagrees with full");

   // head two cells stay in priority order
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_vec[1] |-> (cell_entry[0].prio <= cell_entry[1].prio))
      else $error("head cells out of order");

   // a successful pop shrinks the queue by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("pop did not decrement count");
`endif

endmodule
